FILE: hw/rtl/btnar_pkg.sv
// shared types, constants and register codes of the button autorepeat unit
`timescale 1ns / 1ps
package btnar_pkg;

  // pad geometry
  localparam int NUM_PADS        = 4;
  localparam int BUTTONS_PER_PAD = 16;

  // field and storage widths
  localparam int BTN_W    = 16;
  localparam int PAD_W    = 2;
  localparam int PADS_MAX = 1 << PAD_W;
  localparam int CNT_W    = 9;
  localparam int CFG_W    = 8;
  localparam int DIFF_W   = CNT_W + 1;
  localparam int STEP_W   = $clog2(DIFF_W);
  localparam int ROW_W    = BTN_W * CNT_W;

  // lanes that hold a real button (button j sits at bit BTN_W-1-j)
  localparam logic [BTN_W-1:0] LANE_MASK =
    BTN_W'(((1 << BUTTONS_PER_PAD) - 1) << (BTN_W - BUTTONS_PER_PAD));

  // item queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // apb register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_DELAY  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PERIOD = 3'd1;
  localparam logic [IDX_W-1:0] REG_MASK0  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MASK1  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MASK2  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MASK3  = 3'd5;

  localparam logic [CFG_W-1:0] RESET_DELAY  = 8'h14;
  localparam logic [CFG_W-1:0] RESET_PERIOD = 8'd4;

  // item opcodes
  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_PRIME = 1'b1;

  // queued item: for a prime the word is the one-hot lane to load
  typedef struct packed {
    logic             op;
    logic [PAD_W-1:0] pad;
    logic [BTN_W-1:0] word;
  } btnar_item_t;

  typedef struct packed {
    logic [CFG_W-1:0]                 delay;
    logic [CFG_W-1:0]                 period;
    logic [PADS_MAX-1:0][BTN_W-1:0]   enable;
  } btnar_cfg_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } btnar_qstat_t;

  typedef struct packed {
    logic busy;
  } btnar_bstat_t;

endpackage

FILE: hw/rtl/button_autorepeat_edge_detect_unit.sv
// top level: apb registers, front end, item queue and back end of the button autorepeat unit
// a poll item passes the item queue, the counter ram read and the output register; an
//   output stall holds the item in ST_EXEC or ST_FIN
// the back end takes one item at a time, reading then writing the pad's counter row in the
//   counter ram; a poll of a held enabled button whose stored count is at least
//   delay+2*period-1 (only after a configuration change) runs the bit-serial remainder unit
// reset: synchronous active-low rst_n clears the queue, counter row valid bits, last words
//   and the output register; registers return to delay 20, period 4, masks zero
`timescale 1ns / 1ps
module button_autorepeat_edge_detect_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [btnar_pkg::PAD_W-1:0]     in_pad,
  input  logic [btnar_pkg::BTN_W-1:0]     in_buttons,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [btnar_pkg::BTN_W-1:0]     out_held,
  output logic [btnar_pkg::BTN_W-1:0]     out_pressed,
  output logic [btnar_pkg::BTN_W-1:0]     out_repeat_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [btnar_pkg::ADDR_W-1:0]    paddr,
  input  logic [btnar_pkg::DATA_W-1:0]    pwdata,
  output logic [btnar_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  btnar_pkg::btnar_cfg_t      cfg_r, cfg_nxt;
  btnar_pkg::btnar_qstat_t    q_stat;
  btnar_pkg::btnar_bstat_t    bk_stat;
  btnar_pkg::btnar_item_t     push_item, head_item;
  logic                       q_push, q_pop, head_valid, wr_en;
  logic [btnar_pkg::IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[btnar_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        btnar_pkg::REG_DELAY:  cfg_nxt.delay     = pwdata[btnar_pkg::CFG_W-1:0];
        btnar_pkg::REG_PERIOD: cfg_nxt.period    = pwdata[btnar_pkg::CFG_W-1:0];
        btnar_pkg::REG_MASK0:  cfg_nxt.enable[0] = pwdata[btnar_pkg::BTN_W-1:0];
        btnar_pkg::REG_MASK1:  cfg_nxt.enable[1] = pwdata[btnar_pkg::BTN_W-1:0];
        btnar_pkg::REG_MASK2:  cfg_nxt.enable[2] = pwdata[btnar_pkg::BTN_W-1:0];
        btnar_pkg::REG_MASK3:  cfg_nxt.enable[3] = pwdata[btnar_pkg::BTN_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay  <= btnar_pkg::RESET_DELAY;
      cfg_r.period <= btnar_pkg::RESET_PERIOD;
      cfg_r.enable <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      btnar_pkg::REG_DELAY:  prdata = btnar_pkg::DATA_W'(cfg_r.delay);
      btnar_pkg::REG_PERIOD: prdata = btnar_pkg::DATA_W'(cfg_r.period);
      btnar_pkg::REG_MASK0:  prdata = btnar_pkg::DATA_W'(cfg_r.enable[0]);
      btnar_pkg::REG_MASK1:  prdata = btnar_pkg::DATA_W'(cfg_r.enable[1]);
      btnar_pkg::REG_MASK2:  prdata = btnar_pkg::DATA_W'(cfg_r.enable[2]);
      btnar_pkg::REG_MASK3:  prdata = btnar_pkg::DATA_W'(cfg_r.enable[3]);
      default:               prdata = '0;
    endcase
  end

  // front end
  btnar_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_pad     (in_pad),
    .in_buttons (in_buttons),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  // item queue
  btnar_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .stat       (q_stat)
  );

  // back end
  btnar_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (head_valid),
    .q_item         (head_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_held       (out_held),
    .out_pressed    (out_pressed),
    .out_repeat_res (out_repeat_res),
    .stat           (bk_stat)
  );

  // no result may be pending right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // an item pushed into an empty queue is still there next cycle
  a_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_stat.count == '0) |=> q_stat.count != '0)
    else $error("pushed item lost from queue");

  // a new result only appears when the back end was working on an item
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.busy))
    else $error("result without a busy back end");

endmodule

FILE: hw/rtl/btnar_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module btnar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/btnar_front.sv
// front end: accepts items, drops ignored ones and reduces prime masks to one lane
`timescale 1ns / 1ps
module btnar_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [btnar_pkg::PAD_W-1:0]   in_pad,
  input  logic [btnar_pkg::BTN_W-1:0]   in_buttons,
  input  btnar_pkg::btnar_qstat_t       q_stat,
  output logic                          q_push,
  output btnar_pkg::btnar_item_t        q_item
);

  logic                        pad_ok;
  logic [btnar_pkg::BTN_W-1:0] low_bit;
  logic                        keep;

  // lowest set bit of the prime mask names the button
  assign low_bit = in_buttons & (~in_buttons + btnar_pkg::BTN_W'(1));
  assign pad_ok  = {1'b0, in_pad} < (btnar_pkg::PAD_W + 1)'(btnar_pkg::NUM_PADS);

  // classify: polls of live pads pass, primes need a live button lane
  always_comb begin
    keep = 1'b0;
    if (pad_ok) begin
      if (in_opcode == btnar_pkg::OP_POLL) begin
        keep = 1'b1;
      end else begin
        keep = (low_bit & btnar_pkg::LANE_MASK) != '0;
      end
    end
  end

  assign in_ready    = !q_stat.full;
  assign q_push      = in_valid && in_ready && keep;
  assign q_item.op   = in_opcode;
  assign q_item.pad  = in_pad;
  assign q_item.word = (in_opcode == btnar_pkg::OP_POLL) ? in_buttons : low_bit;

endmodule

FILE: hw/rtl/btnar_queue.sv
// two-entry item queue between front and back end
`timescale 1ns / 1ps
module btnar_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  btnar_pkg::btnar_item_t    push_item,
  input  logic                      pop,
  output logic                      head_valid,
  output btnar_pkg::btnar_item_t    head_item,
  output btnar_pkg::btnar_qstat_t   stat
);

  btnar_pkg::btnar_item_t              entry_r [btnar_pkg::QDEPTH];
  logic [btnar_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [btnar_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [btnar_pkg::QCNT_W-1:0]        count_r, count_nxt;
  logic                                do_push, do_pop;

  assign stat.count = count_r;
  assign stat.full  = count_r == btnar_pkg::QCNT_W'(btnar_pkg::QDEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = entry_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + btnar_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + btnar_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + btnar_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - btnar_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/btnar_back.sv
// back end: per-pad counter row read-modify-write, repeat decision and result register
`timescale 1ns / 1ps
module btnar_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btnar_pkg::btnar_cfg_t         cfg,
  input  logic                          q_valid,
  input  btnar_pkg::btnar_item_t        q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [btnar_pkg::BTN_W-1:0]   out_held,
  output logic [btnar_pkg::BTN_W-1:0]   out_pressed,
  output logic [btnar_pkg::BTN_W-1:0]   out_repeat_res,
  output btnar_pkg::btnar_bstat_t       stat
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_MOD  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  localparam logic [btnar_pkg::STEP_W-1:0] STEP_TOP = btnar_pkg::STEP_W'(btnar_pkg::DIFF_W - 1);

  state_t                                          state_r, state_nxt;
  btnar_pkg::btnar_item_t                          cur_r;
  logic                                            cur_valid_r;
  logic [btnar_pkg::PADS_MAX-1:0]                  row_valid_r, row_valid_nxt;
  logic [btnar_pkg::PADS_MAX-1:0][btnar_pkg::BTN_W-1:0] last_r, last_nxt;
  logic [btnar_pkg::BTN_W-1:0][btnar_pkg::CFG_W-1:0]    rem_r, rem_nxt, rem_step;
  logic [btnar_pkg::STEP_W-1:0]                    step_r, step_nxt;
  logic                                            out_valid_r, out_valid_nxt;
  logic [btnar_pkg::BTN_W-1:0]                     held_r, pressed_r, repeat_r;

  logic                                            ram_re, ram_we;
  logic [btnar_pkg::ROW_W-1:0]                     ram_rdata, ram_wdata;

  logic [btnar_pkg::CFG_W-1:0]                     per;
  logic [btnar_pkg::CNT_W-1:0]                     prime_val;
  logic [btnar_pkg::BTN_W-1:0][btnar_pkg::CNT_W-1:0]  old_cnt, new_cnt;
  logic [btnar_pkg::BTN_W-1:0][btnar_pkg::DIFF_W-1:0] n_cnt, diff;
  logic [btnar_pkg::BTN_W-1:0][btnar_pkg::CFG_W-1:0]  fast_rem, r_sel;
  logic [btnar_pkg::BTN_W-1:0][btnar_pkg::CFG_W:0]    rem_t;
  logic [btnar_pkg::BTN_W-1:0]                     ge, big, fire, act, rep_mask;
  logic                                            is_poll, slow_need, out_free, load_out;

  // counter rows, one per pad
  btnar_ram #(
    .WIDTH (btnar_pkg::ROW_W),
    .DEPTH (btnar_pkg::PADS_MAX)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r.pad),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_item.pad),
    .rdata (ram_rdata)
  );

  // effective period and prime load value
  assign per       = (cfg.period == '0) ? btnar_pkg::CFG_W'(1) : cfg.period;
  assign prime_val = btnar_pkg::CNT_W'({1'b0, cfg.delay} + {1'b0, per} - 9'd1);
  assign is_poll   = cur_r.op == btnar_pkg::OP_POLL;

  // per-lane hold counter update
  always_comb begin
    slow_need = 1'b0;
    for (int k = 0; k < btnar_pkg::BTN_W; k++) begin
      old_cnt[k] = cur_valid_r ? ram_rdata[k*btnar_pkg::CNT_W +: btnar_pkg::CNT_W] : '0;
      n_cnt[k]   = {1'b0, old_cnt[k]} + btnar_pkg::DIFF_W'(1);
      ge[k]      = n_cnt[k] >= {2'b00, cfg.delay};
      diff[k]    = n_cnt[k] - {2'b00, cfg.delay};
      big[k]     = diff[k] >= {1'b0, per, 1'b0};
      fast_rem[k] = (diff[k] >= {2'b00, per}) ? btnar_pkg::CFG_W'(diff[k] - {2'b00, per})
                                               : diff[k][btnar_pkg::CFG_W-1:0];
      r_sel[k]   = (state_r == ST_FIN) ? rem_r[k] : fast_rem[k];
      new_cnt[k] = ge[k] ? ({1'b0, cfg.delay} + {1'b0, r_sel[k]})
                         : n_cnt[k][btnar_pkg::CNT_W-1:0];
      fire[k]    = (n_cnt[k] == btnar_pkg::DIFF_W'(1)) || (ge[k] && r_sel[k] == '0);
      act[k]     = cfg.enable[cur_r.pad][k] && btnar_pkg::LANE_MASK[k];
      rep_mask[k] = is_poll && act[k] && cur_r.word[k] && fire[k];
      slow_need  = slow_need || (act[k] && cur_r.word[k] && ge[k] && big[k]);
      // restoring remainder, one dividend bit per cycle
      rem_t[k]    = {rem_r[k], diff[k][step_r]};
      rem_step[k] = (rem_t[k] >= {1'b0, per}) ? btnar_pkg::CFG_W'(rem_t[k] - {1'b0, per})
                                              : rem_t[k][btnar_pkg::CFG_W-1:0];
      // row write data
      if (is_poll) begin
        if (act[k]) begin
          ram_wdata[k*btnar_pkg::CNT_W +: btnar_pkg::CNT_W] = cur_r.word[k] ? new_cnt[k] : '0;
        end else begin
          ram_wdata[k*btnar_pkg::CNT_W +: btnar_pkg::CNT_W] = old_cnt[k];
        end
      end else begin
        ram_wdata[k*btnar_pkg::CNT_W +: btnar_pkg::CNT_W] = cur_r.word[k] ? prime_val
                                                                           : old_cnt[k];
      end
    end
    slow_need = slow_need && is_poll;
  end

  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ram_re    = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slow_need) begin
          step_nxt  = STEP_TOP;
          rem_nxt   = '0;
          state_nxt = ST_MOD;
        end else if (!is_poll) begin
          ram_we    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ram_we    = 1'b1;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD: begin
        rem_nxt = rem_step;
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r - btnar_pkg::STEP_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ram_we    = 1'b1;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // row valid bits, last poll words and result handshake
  always_comb begin
    row_valid_nxt = row_valid_r;
    last_nxt      = last_r;
    if (ram_we) begin
      row_valid_nxt[cur_r.pad] = 1'b1;
    end
    if (load_out) begin
      last_nxt[cur_r.pad] = cur_r.word;
    end
    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_valid_r <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    if (q_pop) begin
      cur_r       <= q_item;
      cur_valid_r <= row_valid_r[q_item.pad];
    end
    if (load_out) begin
      held_r    <= cur_r.word;
      pressed_r <= cur_r.word & ~last_r[cur_r.pad];
      repeat_r  <= rep_mask;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_held       = held_r;
  assign out_pressed    = pressed_r;
  assign out_repeat_res = repeat_r;
  assign stat.busy      = state_r != ST_IDLE;

endmodule
